FILE: design/itoa_pkg.sv
// Shared constants and helpers for the integer to ASCII converter.
package itoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned RADIX_W        = 6;
  localparam int unsigned CHAR_W         = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
  localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;  // 'x'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;  // '-'

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d > DIGIT_MAX) res = CHAR_A + CHAR_W'(d) - CHAR_W'(DIGIT_MAX) - 8'd1;
    else res = CHAR_ZERO + CHAR_W'(d);
    return res;
  endfunction

endpackage

FILE: design/itoa_in_if.sv
// Input channel: integer value and radix with valid/ready.
interface itoa_in_if #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
);
  import itoa_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic        [RADIX_W-1:0]    radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

FILE: design/itoa_out_if.sv
// Output channel: one ASCII character per transaction, with last flag.
interface itoa_out_if;
  import itoa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: design/itoa_div.sv
// Bit-serial restoring divider: VALUE_BITS-bit dividend by a 6-bit radix.
module itoa_div #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [VALUE_BITS-1:0]            dividend_i,
  input  logic [itoa_pkg::RADIX_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [VALUE_BITS-1:0]            quot_o,
  output logic [itoa_pkg::RADIX_W-1:0]     rem_o
);
  import itoa_pkg::*;

  localparam int unsigned CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    div_q;
  logic [RADIX_W:0]      rem_sh;
  logic [RADIX_W-1:0]    rem_sub;
  logic                  ge;

  // One quotient bit per cycle, MSB first; partial remainder stays below the radix
  always_comb begin
    rem_sh  = {rem_q, quo_q[VALUE_BITS-1]};
    ge      = rem_sh >= {1'b0, div_q};
    // difference is below the radix when taken, so the low bits suffice
    rem_sub = rem_sh[RADIX_W-1:0] - div_q;
    rem_d   = ge ? rem_sub : rem_sh[RADIX_W-1:0];
    quo_d   = {quo_q[VALUE_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(VALUE_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/integer_to_ascii_radix.sv
// Top level: converts an integer to its ASCII text in a radix from 2 to 36.
//
// in_i carries value and radix; a transaction is taken only while the block
// is idle. out_o delivers the text one character per transaction, most
// significant first, with last set on the final character. Base 10 negative
// values get a leading '-', nonzero base 16 text gets a "0x" prefix, zero is "0".
//
// Digits come from a bit-serial divider: each digit takes VALUE_BITS
// iterations of the shared restoring divider plus a start and a write-back
// step. Characters are pushed onto a register stack LSD first and then
// popped at one per cycle while the receiver holds ready high. The next
// number is accepted in the cycle after the last character is taken.
//
// Reset returns the control to idle and empties the stack. When the
// receiver holds ready low the current character stays on out_o and the
// block waits; nothing is dropped.
module integer_to_ascii_radix #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itoa_in_if.sink     in_i,
  itoa_out_if.source  out_o
);
  import itoa_pkg::*;

  localparam int unsigned DEPTH = VALUE_BITS;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_HEX_X,
    ST_HEX_0,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic [RADIX_W-1:0]    base_q;
  logic                  neg_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [CHAR_W-1:0]     stack_q [DEPTH];

  logic [RADIX_W-1:0]    base_in;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] value_u, mag_in;
  logic                  in_acc, out_acc;
  logic                  push_en;
  logic [CHAR_W-1:0]     push_ch;
  logic                  div_start, div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;

  itoa_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (base_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign in_i.ready      = (state_q == ST_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign out_o.valid     = (state_q == ST_EMIT);
  assign out_o.character = stack_q[0];
  assign out_o.last      = (cnt_q == CNT_W'(1));
  assign out_acc         = out_o.valid && out_o.ready;
  assign div_start       = (state_q == ST_DIV_GO);

  always_comb begin
    value_u = VALUE_BITS'(in_i.value);
    base_in = clamp_radix(in_i.radix);
    neg_in  = (base_in == RADIX_DEC) && value_u[VALUE_BITS-1];
    mag_in  = neg_in ? (~value_u + 1'b1) : value_u;
  end

  always_comb begin
    push_en = 1'b0;
    push_ch = CHAR_ZERO;
    case (state_q)
      ST_IDLE: begin
        push_en = in_acc && (value_u == '0);
        push_ch = CHAR_ZERO;
      end
      ST_DIV_WAIT: begin
        push_en = div_done;
        push_ch = digit_char(div_rem);
      end
      ST_SIGN: begin
        push_en = 1'b1;
        push_ch = CHAR_MINUS;
      end
      ST_HEX_X: begin
        push_en = 1'b1;
        push_ch = CHAR_X;
      end
      ST_HEX_0: begin
        push_en = 1'b1;
        push_ch = CHAR_ZERO;
      end
      default: begin
        push_en = 1'b0;
        push_ch = CHAR_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      if (push_en) cnt_q <= cnt_q + 1'b1;
      else if (out_acc) cnt_q <= cnt_q - 1'b1;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            neg_q   <= neg_in;
            state_q <= (value_u == '0) ? ST_EMIT : ST_DIV_GO;
          end
        end
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (div_quot != '0) state_q <= ST_DIV_GO;
            else if (neg_q) state_q <= ST_SIGN;
            else if (base_q == RADIX_HEX) state_q <= ST_HEX_X;
            else state_q <= ST_EMIT;
          end
        end
        ST_SIGN:  state_q <= ST_EMIT;
        ST_HEX_X: state_q <= ST_HEX_0;
        ST_HEX_0: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (out_acc && cnt_q == CNT_W'(1)) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Working magnitude and radix
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mag_q  <= mag_in;
      base_q <= base_in;
    end else if (state_q == ST_DIV_WAIT && div_done) begin
      mag_q <= div_quot;
    end
  end

  // Character stack: push at the top, pop from the top
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_q[0] <= push_ch;
      for (int i = 1; i < DEPTH; i++) stack_q[i] <= stack_q[i-1];
    end else if (out_acc) begin
      for (int i = 0; i < DEPTH - 1; i++) stack_q[i] <= stack_q[i+1];
    end
  end

endmodule

FILE: bench/integer_to_ascii_radix_test.sv
// Self-checking bench for integer_to_ascii_radix: random and corner numbers, text checked per char.
`timescale 1ns / 100ps

module integer_to_ascii_radix_test;
  import itoa_pkg::*;

  localparam int unsigned NUM_BITS     = VALUE_BITS_DEF;
  localparam int unsigned RANDOM_NUMS  = 386;
  localparam int unsigned LIMIT_CYCLES = 2_500_000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [NUM_BITS-1:0] num;
    logic [RADIX_W-1:0]  radix;
  } number_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  itoa_in_if #(.VALUE_BITS(NUM_BITS)) num_bus ();
  itoa_out_if                         text_bus ();

  integer_to_ascii_radix #(.VALUE_BITS(NUM_BITS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (num_bus),
    .out_o  (text_bus)
  );

  number_item_t pending_numbers[$];
  text_char_t   expected_text[$];

  int unsigned total_numbers;
  int unsigned accepted_numbers;
  int unsigned checked_chars;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned ready_phase;
  logic [7:0]  ready_pattern;
  logic        bus_holding;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Builds the expected characters of one number, most significant first.
  function automatic void predict_text(input logic [NUM_BITS-1:0] num,
                                       input logic [RADIX_W-1:0] radix_raw);
    logic [NUM_BITS-1:0] mag;
    logic [CHAR_W-1:0]   rev[$];
    logic [CHAR_W-1:0]   ch;
    int unsigned         base;
    int unsigned         digit;
    text_char_t          tc;
    base = int'(radix_raw);
    if (base < int'(RADIX_MIN)) base = int'(RADIX_MIN);
    if (base > int'(RADIX_MAX)) base = int'(RADIX_MAX);
    mag = num;
    if (mag == '0) begin
      rev.push_back(CHAR_ZERO);
    end else begin
      if (base == int'(RADIX_DEC) && mag[NUM_BITS-1]) mag = -mag;
      while (mag != '0) begin
        digit = 32'(mag % NUM_BITS'(base));
        if (digit > int'(DIGIT_MAX)) ch = CHAR_A + CHAR_W'(digit - 10);
        else ch = CHAR_ZERO + CHAR_W'(digit);
        rev.push_back(ch);
        mag = mag / NUM_BITS'(base);
      end
      if (base == int'(RADIX_DEC) && num[NUM_BITS-1]) rev.push_back(CHAR_MINUS);
      if (base == int'(RADIX_HEX)) begin
        rev.push_back(CHAR_X);
        rev.push_back(CHAR_ZERO);
      end
    end
    for (int k = rev.size() - 1; k >= 0; k--) begin
      tc.ch   = rev[k];
      tc.last = (k == 0);
      expected_text.push_back(tc);
    end
  endfunction

  function automatic void add_number(input logic [NUM_BITS-1:0] num,
                                     input logic [RADIX_W-1:0] radix);
    number_item_t it;
    it.num   = num;
    it.radix = radix;
    pending_numbers.push_back(it);
  endfunction

  // Sender: bursts of numbers separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bus.valid <= 1'b0;
      num_bus.value <= '0;
      num_bus.radix <= '0;
      gap_left      = 0;
      burst_left    = 0;
    end else begin
      bus_holding = num_bus.valid;
      if (num_bus.valid && num_bus.ready) begin
        predict_text(pending_numbers[0].num, pending_numbers[0].radix);
        void'(pending_numbers.pop_front());
        accepted_numbers++;
        bus_holding = 1'b0;
        if (burst_left > 0) burst_left--;
      end
      if (!bus_holding) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          num_bus.valid <= 1'b0;
          num_bus.value <= NUM_BITS'($urandom);
          num_bus.radix <= RADIX_W'($urandom);
        end else if (pending_numbers.size() != 0) begin
          num_bus.valid <= 1'b1;
          num_bus.value <= pending_numbers[0].num;
          num_bus.radix <= pending_numbers[0].radix;
        end else begin
          num_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each character; ready follows a rotating 8-bit pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_bus.ready <= 1'b0;
      ready_phase    = 0;
      ready_pattern  = 8'hff;
    end else begin
      if (text_bus.valid && text_bus.ready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character %h last %b", $time,
                   text_bus.character, text_bus.last);
          error_count++;
        end else begin
          if (text_bus.character !== expected_text[0].ch) begin
            $display("%0t: character mismatch, expected %h actual %h", $time,
                     expected_text[0].ch, text_bus.character);
            error_count++;
          end
          if (text_bus.last !== expected_text[0].last) begin
            $display("%0t: last mismatch, expected %b actual %b", $time,
                     expected_text[0].last, text_bus.last);
            error_count++;
          end
          void'(expected_text.pop_front());
        end
        checked_chars++;
      end
      ready_phase++;
      if (ready_phase % 64 == 0) begin
        // a third of the windows run without back-pressure
        if ($urandom_range(0, 2) == 0) ready_pattern = 8'hff;
        else ready_pattern = 8'($urandom) | 8'h01;
      end
      text_bus.ready <= ready_pattern[ready_phase[2:0]];
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d of %0d numbers accepted, %0d chars pending", $time,
               accepted_numbers, total_numbers, expected_text.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [NUM_BITS-1:0] v;
    logic [RADIX_W-1:0]  r;

    // zero, extremes, sign and prefix cases, clamped radixes
    add_number('0, RADIX_DEC);
    add_number('0, RADIX_HEX);
    add_number('0, RADIX_MIN);
    add_number(32'd1, RADIX_MIN);
    add_number(32'h7fffffff, RADIX_DEC);
    add_number(32'h80000000, RADIX_DEC);
    add_number(32'hffffffff, RADIX_DEC);
    add_number(32'hffffffff, RADIX_MIN);
    add_number(32'hffffffff, RADIX_HEX);
    add_number(32'hffffffff, RADIX_MAX);
    add_number(32'h80000000, RADIX_HEX);
    add_number(32'd12345, 6'd0);
    add_number(32'd12345, 6'd1);
    add_number(32'd12345, 6'd37);
    add_number(32'hdeadbeef, 6'd63);
    add_number(32'd35, RADIX_MAX);
    add_number(32'd36, RADIX_MAX);
    add_number(32'd255, RADIX_HEX);
    add_number(32'd12345, 6'd8);
    add_number(-32'sd42, RADIX_DEC);
    add_number(32'h12345678, RADIX_HEX);
    add_number(32'd9, RADIX_DEC);
    add_number(32'd10, 6'd11);
    add_number(32'h55555555, 6'd3);
    add_number(32'haaaaaaaa, 6'd7);

    for (int i = 0; i < RANDOM_NUMS; i++) begin
      case ($urandom_range(0, 5))
        0, 1: v = $urandom;
        2: v = $urandom_range(0, 99);
        3: v = -$urandom_range(1, 1000);
        4: v = 32'hffffffff >> $urandom_range(0, 31);
        default: v = 32'd1 << $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 9))
        0, 1: r = RADIX_DEC;
        2, 3: r = RADIX_HEX;
        4: r = RADIX_W'($urandom_range(0, 63));
        default: r = RADIX_W'($urandom_range(2, 36));
      endcase
      add_number(v, r);
    end
    total_numbers = pending_numbers.size();

    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_numbers < total_numbers || expected_text.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers into %0d characters, bases 2..36 plus clamped ones,",
             accepted_numbers, checked_chars);
    $display("with sender gaps and receiver back-pressure; %0d errors.", error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
